/* src/control_mapped_word_deframer_assert.svh */
// assertion macros shared by the checker
`ifndef CONTROL_MAPPED_WORD_DEFRAMER_ASSERT_SVH
`define CONTROL_MAPPED_WORD_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CMWD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");

// next-cycle implication, disabled during reset
`define CMWD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");

`endif

/* src/cmwd_pkg.sv */
package cmwd_pkg;

	localparam int NUM_LANES  = 7;
	localparam int LANE_IDX_W = 3;
	localparam int MAP_SHIFT  = 56;
	localparam int TAG_SHIFT  = 60;

	localparam logic [7:0] CTRL_EOP  = 8'hDC;
	localparam logic [7:0] CTRL_SOP  = 8'h3C;
	localparam logic [7:0] CTRL_IDLE = 8'h00;
	localparam logic [3:0] TS_TAG    = 4'hF;

	localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_EOP  = 2'd1,
		KIND_TS   = 2'd2,
		KIND_BAD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CLS_DATA   = 2'd0,
		CLS_EOP    = 2'd1,
		CLS_IGNORE = 2'd2,
		CLS_BAD    = 2'd3
	} lane_cls_t;

	typedef struct packed {
		lane_cls_t  cls;
		logic [7:0] data;
	} lane_t;

	typedef struct packed {
		logic                        is_ts;
		lane_t [NUM_LANES-1:0]       lanes;
		logic [15:0]                 stream;
	} item_t;

endpackage

/* src/cmwd_if.sv */
interface cmwd_word_if import cmwd_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [63:0] link_word;
	logic [15:0] stream_id;

	modport source(output valid, link_word, stream_id, input ready);
	modport sink(input valid, link_word, stream_id, output ready);
endinterface

interface cmwd_result_if import cmwd_pkg::*; ();
	logic        valid;
	logic        ready;
	kind_t       kind;
	logic [31:0] data_word;
	logic [2:0]  valid_bytes;
	logic [15:0] stream_out;

	modport source(output valid, kind, data_word, valid_bytes, stream_out, input ready);
	modport sink(input valid, kind, data_word, valid_bytes, stream_out, output ready);
endinterface

/* src/cmwd_lane.sv */
module cmwd_lane import cmwd_pkg::*; (
	input  logic [7:0] lane_byte,
	input  logic       ctrl,
	output lane_t      lane
);

	always_comb begin
		lane.data = lane_byte;
		if (!ctrl) begin
			lane.cls = CLS_DATA;
		end else if (lane_byte == CTRL_EOP) begin
			lane.cls = CLS_EOP;
		end else if (lane_byte == CTRL_SOP || lane_byte == CTRL_IDLE) begin
			lane.cls = CLS_IGNORE;
		end else begin
			lane.cls = CLS_BAD;
		end
	end

endmodule

/* src/cmwd_merge.sv */
module cmwd_merge import cmwd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  item_t                item,
	cmwd_result_if.source        results
);

	logic                  s1_valid_q;
	item_t                 item_s1;
	logic [LANE_IDX_W-1:0] lane_q;

	logic [23:0] partial_q;
	logic [1:0]  pos_q;
	logic        has_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [31:0] data_q;
	logic [2:0]  bytes_q;
	logic [15:0] stream_q;

	logic        slot_free, step, last, done;
	lane_t       cur;
	logic        emit;
	kind_t       r_kind;
	logic [31:0] r_data;
	logic [2:0]  r_bytes;
	logic [23:0] partial_d;
	logic [1:0]  pos_d;
	logic        has_d;

	assign slot_free = !out_valid_q || results.ready;
	assign step      = s1_valid_q && slot_free;
	assign last      = item_s1.is_ts || (lane_q == '0);
	assign done      = step && last;
	assign in_ready  = !s1_valid_q || done;

	// one lane per cycle while the output slot is free, most significant lane first
	always_comb begin
		cur       = item_s1.lanes[lane_q];
		emit      = 1'b0;
		r_kind    = KIND_DATA;
		r_data    = '0;
		r_bytes   = '0;
		partial_d = partial_q;
		pos_d     = pos_q;
		has_d     = has_q;
		if (item_s1.is_ts) begin
			emit      = has_q;
			r_kind    = KIND_TS;
			r_data    = {8'h00, partial_q};
			r_bytes   = {1'b0, pos_q};
			partial_d = '0;
			pos_d     = '0;
			has_d     = 1'b0;
		end else begin
			case (cur.cls)
				CLS_DATA: begin
					has_d = 1'b1;
					if (pos_q == 2'd3) begin
						emit      = 1'b1;
						r_kind    = KIND_DATA;
						r_data    = {cur.data, partial_q};
						r_bytes   = FULL_WORD_BYTES;
						partial_d = '0;
						pos_d     = '0;
					end else begin
						case (pos_q)
							2'd0: partial_d[7:0]   = cur.data;
							2'd1: partial_d[15:8]  = cur.data;
							default: partial_d[23:16] = cur.data;
						endcase
						pos_d = pos_q + 2'd1;
					end
				end
				CLS_EOP: begin
					emit      = 1'b1;
					r_kind    = KIND_EOP;
					r_data    = {8'h00, partial_q};
					r_bytes   = {1'b0, pos_q};
					partial_d = '0;
					pos_d     = '0;
					has_d     = 1'b0;
				end
				CLS_BAD: begin
					emit    = 1'b1;
					r_kind  = KIND_BAD;
					r_data  = {24'h000000, cur.data};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			lane_q      <= '0;
			partial_q   <= '0;
			pos_q       <= '0;
			has_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
				lane_q     <= LANE_IDX_W'(NUM_LANES - 1);
			end else if (done) begin
				s1_valid_q <= 1'b0;
			end else if (step) begin
				lane_q <= lane_q - LANE_IDX_W'(1);
			end
			if (step) begin
				partial_q <= partial_d;
				pos_q     <= pos_d;
				has_q     <= has_d;
			end
			if (step && emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
		if (step && emit) begin
			kind_q   <= r_kind;
			data_q   <= r_data;
			bytes_q  <= r_bytes;
			stream_q <= item_s1.stream;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.kind        = kind_q;
	assign results.data_word   = data_q;
	assign results.valid_bytes = bytes_q;
	assign results.stream_out  = stream_q;

endmodule

/* src/control_mapped_word_deframer.sv */
// deframer for control-mapped 64-bit link words
// words: sink channel, one link word plus its stream id per transfer
// results: source channel, one packed 32-bit data word, packet end,
//   timestamp flush or bad-control report per transfer, tagged with the stream id of its word
// seven lane classifiers decode the control map and byte values as a word
//   is taken; the word is then held in a stage register and the merge walks
//   its lanes one per cycle, most significant first, keeping the open packet
// a data/control word occupies the walker for all seven lanes, a
//   timestamp word for a single step
// the top lane's result passes the stage register and then the output
//   register; lower lanes follow as the walk advances while the receiver keeps up
// a new word is taken in the cycle the walker finishes the previous one
// the walker advances only when the output register is empty or being
//   drained, so a stalled receiver holds the result and pauses the walk,
//   and back-pressure reaches the word channel once the stage is full
// reset clears the open packet (no bytes, position zero) and empties both
//   the stage register and the output register
module control_mapped_word_deframer import cmwd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	cmwd_word_if.sink     words,
	cmwd_result_if.source results
);

	item_t item;

	assign item.is_ts  = (words.link_word[63:TAG_SHIFT] == TS_TAG);
	assign item.stream = words.stream_id;

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		cmwd_lane u_lane (
			.lane_byte (words.link_word[i*8 +: 8]),
			.ctrl      (words.link_word[MAP_SHIFT + i]),
			.lane      (item.lanes[i])
		);
	end

	cmwd_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (words.valid),
		.in_ready (words.ready),
		.item     (item),
		.results  (results)
	);

endmodule

/* src/cmwd_checker.sv */
`include "control_mapped_word_deframer_assert.svh"

module cmwd_checker import cmwd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [31:0] data_word,
	input logic [2:0]  valid_bytes,
	input logic [15:0] stream_out
);

	// a stalled result stays put
	`CMWD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_word) && $stable(valid_bytes) && $stable(stream_out))
	`CMWD_ASSERT_NOW(a_full_word, out_valid && kind == KIND_DATA, valid_bytes == FULL_WORD_BYTES)
	`CMWD_ASSERT_NOW(a_bad_byte, out_valid && kind == KIND_BAD, valid_bytes == 3'd0 && data_word[31:8] == 24'h0)
	// a tail counts at most three bytes, keeps its top byte clear and is all zero when it counts none
	`CMWD_ASSERT_NOW(a_tail, out_valid && (kind == KIND_EOP || kind == KIND_TS), !valid_bytes[2] && (valid_bytes != 3'd0 || data_word == 32'h0) && data_word[31:24] == 8'h0)

endmodule

bind control_mapped_word_deframer cmwd_checker u_cmwd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.kind        (results.kind),
	.data_word   (results.data_word),
	.valid_bytes (results.valid_bytes),
	.stream_out  (results.stream_out)
);
